### hw/rtl/cpvs_pkg.sv
`timescale 1ns / 1ps
// Package for the cooling pin valve sequencer: step codes, operation codes,
// configuration register indexes and the timer constants. No dependencies.
package cpvs_pkg;

  localparam int TIMER_BITS_DEFAULT = 16;
  localparam int CFG_INDEX_BITS     = 2;
  localparam int CFG_DATA_BITS      = 16;
  localparam int STEP_BITS          = 4;
  localparam int SHOW_BITS          = 16;
  localparam int UP_ALARM_DEFAULT   = 500;

  typedef enum logic [STEP_BITS-1:0] {
    ST_IDLE    = 4'd0,
    ST_START   = 4'd1,
    ST_DELAY   = 4'd2,
    ST_PREDOWN = 4'd3,
    ST_DOWN    = 4'd4,
    ST_RELEASE = 4'd5,
    ST_WAITUP  = 4'd6,
    ST_CHECKUP = 4'd7,
    ST_FINISH  = 4'd8,
    ST_HOLD    = 4'd9,
    ST_DONE    = 4'd10,
    ST_MANDOWN = 4'd11,
    ST_MANUP   = 4'd12,
    ST_STOP    = 4'd13,
    ST_RESET   = 4'd14,
    ST_ALARM   = 4'd15
  } step_t;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_PIN_ENABLED    = 2'd0,
    CFG_HOLD_NEXT      = 2'd1,
    CFG_DOWN_DELAY     = 2'd2,
    CFG_UP_ALARM_TICKS = 2'd3
  } cfg_index_t;

endpackage

### hw/rtl/cooling_pin_valve_sequencer.sv
`timescale 1ns / 1ps
// Cooling pin valve sequencer top level: step machine, two on-delay timers
// and the result register. Depends on cpvs_pkg.

// Each accepted beat is one scan tick or one step load; its result beat
// appears in the output register in the next cycle. Input stall is raised
// only while a result beat is held by output stall, so with the output
// side free the block takes one beat per clock. The user must write
// configuration through cfg_we, cfg_index and cfg_data while no beat is
// in flight; the block does not enforce it. The timers count in TIMER_BITS
// bits and the displayed elapsed counts are their low sixteen bits.
module cooling_pin_valve_sequencer #(
  parameter int TIMER_BITS = cpvs_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [cpvs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [cpvs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic [3:0]                          new_step,
  input  logic                                up_limit,
  input  logic                                blow_done,
  input  logic                                clear_alarm,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                valve_down,
  output logic [3:0]                          step_now,
  output logic [15:0]                         delay_elapsed,
  output logic [15:0]                         alarm_elapsed,
  output logic                                not_up_alarm
);

  logic                  pin_enabled;
  logic                  hold_until_next_clamp;
  logic [15:0]           down_delay_ticks;
  logic [15:0]           up_alarm_ticks;

  cpvs_pkg::step_t       step_code, step_next;
  logic                  valve_state, valve_next;
  logic                  delay_running, delay_running_next;
  logic [TIMER_BITS-1:0] delay_count, delay_count_next;
  logic [TIMER_BITS-1:0] delay_preset, delay_preset_next;
  logic                  limit_running, limit_running_next;
  logic [TIMER_BITS-1:0] limit_count, limit_count_next;
  logic [TIMER_BITS-1:0] limit_preset, limit_preset_next;
  logic                  alarm_flag, alarm_next;

  logic                  in_accept;
  logic                  is_scan;
  logic                  delay_done;
  logic                  limit_done;
  logic [15:0]           alarm_set;

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign is_scan   = (cpvs_pkg::op_t'(operation) == cpvs_pkg::OP_SCAN);
  assign alarm_set = (up_alarm_ticks != 16'd0) ? up_alarm_ticks
                                               : 16'(cpvs_pkg::UP_ALARM_DEFAULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_enabled           <= 1'b0;
      hold_until_next_clamp <= 1'b0;
      down_delay_ticks      <= 16'd0;
      up_alarm_ticks        <= 16'd0;
    end else if (cfg_we) begin
      case (cpvs_pkg::cfg_index_t'(cfg_index))
        cpvs_pkg::CFG_PIN_ENABLED:    pin_enabled           <= cfg_data[0];
        cpvs_pkg::CFG_HOLD_NEXT:      hold_until_next_clamp <= cfg_data[0];
        cpvs_pkg::CFG_DOWN_DELAY:     down_delay_ticks      <= cfg_data;
        cpvs_pkg::CFG_UP_ALARM_TICKS: up_alarm_ticks        <= cfg_data;
        default: ;
      endcase
    end
  end

  // Both timers tick before the step rule looks at their done flags.
  always_comb begin
    delay_count_next = delay_count;
    limit_count_next = limit_count;
    delay_done       = 1'b0;
    limit_done       = 1'b0;
    if (is_scan) begin
      if (delay_running) begin
        if (delay_count < delay_preset) begin
          delay_count_next = delay_count + 1'b1;
        end
        delay_done = (delay_count_next >= delay_preset);
      end else begin
        delay_count_next = '0;
      end
      if (limit_running) begin
        if (limit_count < limit_preset) begin
          limit_count_next = limit_count + 1'b1;
        end
        limit_done = (limit_count_next >= limit_preset);
      end else begin
        limit_count_next = '0;
      end
    end
  end

  always_comb begin
    step_next = step_code;
    if (!is_scan) begin
      step_next = cpvs_pkg::step_t'(new_step);
    end else begin
      case (step_code)
        cpvs_pkg::ST_START: begin
          if (!pin_enabled) begin
            step_next = cpvs_pkg::ST_FINISH;
          end else if (hold_until_next_clamp) begin
            step_next = cpvs_pkg::ST_HOLD;
          end else if (down_delay_ticks != 16'd0) begin
            step_next = cpvs_pkg::ST_DELAY;
          end else begin
            step_next = cpvs_pkg::ST_PREDOWN;
          end
        end
        cpvs_pkg::ST_DELAY: begin
          if (delay_done) begin
            step_next = cpvs_pkg::ST_PREDOWN;
          end
        end
        cpvs_pkg::ST_PREDOWN: step_next = cpvs_pkg::ST_DOWN;
        cpvs_pkg::ST_DOWN: begin
          if (blow_done) begin
            step_next = cpvs_pkg::ST_RELEASE;
          end
        end
        cpvs_pkg::ST_RELEASE: begin
          step_next = (pin_enabled || valve_state) ? cpvs_pkg::ST_WAITUP
                                                   : cpvs_pkg::ST_CHECKUP;
        end
        cpvs_pkg::ST_WAITUP: begin
          if (limit_done) begin
            step_next = cpvs_pkg::ST_ALARM;
          end else if (up_limit) begin
            step_next = cpvs_pkg::ST_FINISH;
          end
        end
        cpvs_pkg::ST_CHECKUP: begin
          step_next = up_limit ? cpvs_pkg::ST_FINISH : cpvs_pkg::ST_ALARM;
        end
        cpvs_pkg::ST_FINISH: step_next = cpvs_pkg::ST_DONE;
        cpvs_pkg::ST_STOP,
        cpvs_pkg::ST_RESET:  step_next = cpvs_pkg::ST_IDLE;
        default: ;
      endcase
    end
  end

  always_comb begin
    valve_next         = valve_state;
    delay_running_next = delay_running;
    delay_preset_next  = delay_preset;
    limit_running_next = limit_running;
    limit_preset_next  = limit_preset;
    alarm_next         = alarm_flag && !clear_alarm;
    if (is_scan) begin
      case (step_code)
        cpvs_pkg::ST_IDLE: begin
          delay_running_next = 1'b0;
          limit_running_next = 1'b0;
        end
        cpvs_pkg::ST_START: begin
          if (pin_enabled && !hold_until_next_clamp && down_delay_ticks != 16'd0) begin
            delay_running_next = 1'b1;
            delay_preset_next  = TIMER_BITS'(down_delay_ticks);
          end
        end
        cpvs_pkg::ST_DELAY: begin
          if (delay_done) begin
            delay_running_next = 1'b0;
          end
        end
        cpvs_pkg::ST_DOWN,
        cpvs_pkg::ST_HOLD,
        cpvs_pkg::ST_MANDOWN: valve_next = 1'b1;
        cpvs_pkg::ST_RELEASE: begin
          if (pin_enabled || valve_state) begin
            limit_running_next = 1'b1;
            limit_preset_next  = TIMER_BITS'(alarm_set);
          end
        end
        cpvs_pkg::ST_WAITUP: begin
          valve_next = 1'b0;
          if (limit_done) begin
            limit_running_next = 1'b0;
            alarm_next         = 1'b1;
          end
        end
        cpvs_pkg::ST_CHECKUP: begin
          if (!up_limit) begin
            limit_running_next = 1'b0;
            alarm_next         = 1'b1;
          end
        end
        cpvs_pkg::ST_FINISH: begin
          valve_next         = 1'b0;
          limit_running_next = 1'b0;
        end
        cpvs_pkg::ST_MANUP: valve_next = 1'b0;
        cpvs_pkg::ST_STOP,
        cpvs_pkg::ST_RESET,
        cpvs_pkg::ST_ALARM: begin
          delay_running_next = 1'b0;
          limit_running_next = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_code     <= cpvs_pkg::ST_IDLE;
      valve_state   <= 1'b0;
      delay_running <= 1'b0;
      delay_count   <= '0;
      delay_preset  <= '0;
      limit_running <= 1'b0;
      limit_count   <= '0;
      limit_preset  <= '0;
      alarm_flag    <= 1'b0;
    end else if (in_accept) begin
      step_code     <= step_next;
      valve_state   <= valve_next;
      delay_running <= delay_running_next;
      delay_count   <= delay_count_next;
      delay_preset  <= delay_preset_next;
      limit_running <= limit_running_next;
      limit_count   <= limit_count_next;
      limit_preset  <= limit_preset_next;
      alarm_flag    <= alarm_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      valve_down    <= valve_next;
      step_now      <= step_next;
      delay_elapsed <= cpvs_pkg::SHOW_BITS'(delay_count_next);
      alarm_elapsed <= cpvs_pkg::SHOW_BITS'(limit_count_next);
      not_up_alarm  <= alarm_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted beat did not produce a result beat");

  a_alarm_only_in_alarm_step: assert property (@(posedge clk) disable iff (rst)
    $rose(alarm_flag) |-> step_code == cpvs_pkg::ST_ALARM)
    else $error("alarm raised outside the alarm step");

  a_idle_delay_cleared: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_scan && !delay_running) |=> delay_count == '0)
    else $error("down-delay count not cleared while stopped");

  a_down_drives_valve: assert property (@(posedge clk) disable iff (rst)
    (in_accept && is_scan && step_code == cpvs_pkg::ST_DOWN) |=> valve_state)
    else $error("down step did not drive the valve");
`endif

endmodule

### verif/tb_cooling_pin_valve_sequencer.sv
`timescale 1ns / 1ps
// Testbench for cooling_pin_valve_sequencer: directed step walks, then random scans under
// random source gaps and sink stalls, checked beat by beat against a local step predictor.
// Depends on cpvs_pkg and the cooling_pin_valve_sequencer RTL.
module tb_cooling_pin_valve_sequencer;

  localparam int STUCK_LIMIT = 2000;

  typedef struct {
    cpvs_pkg::op_t   operation;
    cpvs_pkg::step_t new_step;
    logic            up_limit;
    logic            blow_done;
    logic            clear_alarm;
  } valve_beat_t;

  typedef struct {
    logic            valve_down;
    cpvs_pkg::step_t step_now;
    logic [15:0]     delay_elapsed;
    logic [15:0]     alarm_elapsed;
    logic            not_up_alarm;
  } valve_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [cpvs_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [cpvs_pkg::CFG_DATA_BITS-1:0]  cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        operation;
  logic [3:0]  new_step;
  logic        up_limit;
  logic        blow_done;
  logic        clear_alarm;
  logic        out_valid;
  logic        out_stall;
  logic        valve_down;
  logic [3:0]  step_now;
  logic [15:0] delay_elapsed;
  logic [15:0] alarm_elapsed;
  logic        not_up_alarm;

  // Register shadows and the predicted state of the sequencer.
  logic            r_pin_enabled;
  logic            r_hold_next;
  logic [15:0]     r_down_delay;
  logic [15:0]     r_up_alarm;
  cpvs_pkg::step_t m_step;
  logic            m_valve;
  logic            m_alarm;
  logic            m_delay_run;
  logic [15:0]     m_delay_cnt;
  logic [15:0]     m_delay_preset;
  logic            m_limit_run;
  logic [15:0]     m_limit_cnt;
  logic [15:0]     m_limit_preset;

  valve_result_t pending_valve_results[$];
  int            fail_count;
  int            stuck_cycles;
  logic          no_gaps;

  cooling_pin_valve_sequencer i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .new_step      (new_step),
    .up_limit      (up_limit),
    .blow_done     (blow_done),
    .clear_alarm   (clear_alarm),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .valve_down    (valve_down),
    .step_now      (step_now),
    .delay_elapsed (delay_elapsed),
    .alarm_elapsed (alarm_elapsed),
    .not_up_alarm  (not_up_alarm)
  );

  always #4 clk = ~clk;

  function automatic int draw_gap();
    return no_gaps ? 0 : int'($urandom_range(0, 11));
  endfunction

  // One beat: a step load, or a scan tick with both timers updated ahead of the step rule.
  task automatic step_valve_sequence(input valve_beat_t b);
    logic          delay_done;
    logic          limit_done;
    logic [15:0]   limit_target;
    valve_result_t r;
    delay_done = 1'b0;
    limit_done = 1'b0;
    if (b.clear_alarm) m_alarm = 1'b0;
    if (b.operation == cpvs_pkg::OP_LOAD) begin
      m_step = b.new_step;
    end else begin
      if (m_delay_run) begin
        if (m_delay_cnt < m_delay_preset) m_delay_cnt = m_delay_cnt + 16'd1;
        delay_done = (m_delay_cnt >= m_delay_preset);
      end else begin
        m_delay_cnt = '0;
      end
      if (m_limit_run) begin
        if (m_limit_cnt < m_limit_preset) m_limit_cnt = m_limit_cnt + 16'd1;
        limit_done = (m_limit_cnt >= m_limit_preset);
      end else begin
        m_limit_cnt = '0;
      end
      limit_target = (r_up_alarm != 16'd0) ? r_up_alarm : 16'(cpvs_pkg::UP_ALARM_DEFAULT);
      case (m_step)
        cpvs_pkg::ST_IDLE: begin
          m_limit_run = 1'b0;
          m_delay_run = 1'b0;
        end
        cpvs_pkg::ST_START: begin
          if (!r_pin_enabled) m_step = cpvs_pkg::ST_FINISH;
          else if (r_hold_next) m_step = cpvs_pkg::ST_HOLD;
          else if (r_down_delay != 16'd0) begin
            m_delay_run    = 1'b1;
            m_delay_preset = r_down_delay;
            m_step         = cpvs_pkg::ST_DELAY;
          end else m_step = cpvs_pkg::ST_PREDOWN;
        end
        cpvs_pkg::ST_DELAY: begin
          if (delay_done) begin
            m_delay_run = 1'b0;
            m_step      = cpvs_pkg::ST_PREDOWN;
          end
        end
        cpvs_pkg::ST_PREDOWN: m_step = cpvs_pkg::ST_DOWN;
        cpvs_pkg::ST_DOWN: begin
          m_valve = 1'b1;
          if (b.blow_done) m_step = cpvs_pkg::ST_RELEASE;
        end
        cpvs_pkg::ST_RELEASE: begin
          if (r_pin_enabled || m_valve) begin
            m_limit_run    = 1'b1;
            m_limit_preset = limit_target;
            m_step         = cpvs_pkg::ST_WAITUP;
          end else m_step = cpvs_pkg::ST_CHECKUP;
        end
        cpvs_pkg::ST_WAITUP: begin
          m_valve = 1'b0;
          if (b.up_limit) m_step = cpvs_pkg::ST_FINISH;
          if (limit_done) begin
            m_limit_run = 1'b0;
            m_alarm     = 1'b1;
            m_step      = cpvs_pkg::ST_ALARM;
          end
        end
        cpvs_pkg::ST_CHECKUP: begin
          if (b.up_limit) m_step = cpvs_pkg::ST_FINISH;
          else begin
            m_limit_run = 1'b0;
            m_alarm     = 1'b1;
            m_step      = cpvs_pkg::ST_ALARM;
          end
        end
        cpvs_pkg::ST_FINISH: begin
          m_valve     = 1'b0;
          m_limit_run = 1'b0;
          m_step      = cpvs_pkg::ST_DONE;
        end
        cpvs_pkg::ST_HOLD, cpvs_pkg::ST_MANDOWN: m_valve = 1'b1;
        cpvs_pkg::ST_MANUP: m_valve = 1'b0;
        cpvs_pkg::ST_STOP, cpvs_pkg::ST_RESET: begin
          m_delay_run = 1'b0;
          m_limit_run = 1'b0;
          m_step      = cpvs_pkg::ST_IDLE;
        end
        cpvs_pkg::ST_ALARM: begin
          m_delay_run = 1'b0;
          m_limit_run = 1'b0;
        end
        default: ;
      endcase
    end
    r.valve_down    = m_valve;
    r.step_now      = m_step;
    r.delay_elapsed = m_delay_cnt;
    r.alarm_elapsed = m_limit_cnt;
    r.not_up_alarm  = m_alarm;
    pending_valve_results.push_back(r);
  endtask

  // Returns at a falling edge with the accepted beat still on the port; the caller either
  // sends the next beat at once or lowers in_valid.
  task automatic send_beat(input cpvs_pkg::op_t op, input cpvs_pkg::step_t st,
                           input logic up, input logic blow, input logic clr);
    int          gap;
    valve_beat_t b;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    b.operation   = op;
    b.new_step    = st;
    b.up_limit    = up;
    b.blow_done   = blow;
    b.clear_alarm = clr;
    operation     = op;
    new_step      = st;
    up_limit      = up;
    blow_done     = blow;
    clear_alarm   = clr;
    in_valid      = 1'b1;
    do @(posedge clk); while (!(in_valid && in_stall === 1'b0));
    step_valve_sequence(b);
    @(negedge clk);
  endtask

  task automatic load_step(input cpvs_pkg::step_t st, input logic clr);
    send_beat(cpvs_pkg::OP_LOAD, st, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              clr);
  endtask

  task automatic scan(input logic up, input logic blow, input logic clr);
    send_beat(cpvs_pkg::OP_SCAN, cpvs_pkg::step_t'($urandom_range(0, 15)), up, blow, clr);
  endtask

  task automatic settle_block();
    in_valid = 1'b0;
    while (pending_valve_results.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input cpvs_pkg::cfg_index_t idx, input logic [15:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we    = 1'b0;
    case (idx)
      cpvs_pkg::CFG_PIN_ENABLED:    r_pin_enabled = value[0];
      cpvs_pkg::CFG_HOLD_NEXT:      r_hold_next   = value[0];
      cpvs_pkg::CFG_DOWN_DELAY:     r_down_delay  = value;
      cpvs_pkg::CFG_UP_ALARM_TICKS: r_up_alarm    = value;
      default: ;
    endcase
  endtask

  task automatic write_all(input logic pin, input logic hold, input logic [15:0] delay_ticks,
                           input logic [15:0] alarm_ticks);
    settle_block();
    write_reg(cpvs_pkg::CFG_PIN_ENABLED, {15'd0, pin});
    write_reg(cpvs_pkg::CFG_HOLD_NEXT, {15'd0, hold});
    write_reg(cpvs_pkg::CFG_DOWN_DELAY, delay_ticks);
    write_reg(cpvs_pkg::CFG_UP_ALARM_TICKS, alarm_ticks);
  endtask

  function automatic logic [15:0] draw_ticks();
    case ($urandom_range(0, 9))
      0, 1, 2: return 16'd0;
      8:       return 16'hFFFF;
      9:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 8));
    endcase
  endfunction

  // Full cycle: delay, down until blow done, release, then expiry beating the up limit.
  task automatic test_delayed_cycle();
    write_all(1'b1, 1'b0, 16'd2, 16'd1);
    load_step(cpvs_pkg::ST_START, 1'b1);
    scan(1'b0, 1'b0, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    scan(1'b0, 1'b1, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    scan(1'b1, 1'b0, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
  endtask

  // Manual modes drive the valve down and up, stop and reset leave it alone, done is absorbing.
  task automatic test_manual_steps();
    load_step(cpvs_pkg::ST_MANDOWN, 1'b1);
    scan(1'b0, 1'b0, 1'b0);
    load_step(cpvs_pkg::ST_STOP, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    load_step(cpvs_pkg::ST_MANUP, 1'b0);
    scan(1'b1, 1'b1, 1'b0);
    load_step(cpvs_pkg::ST_DONE, 1'b0);
    scan(1'b1, 1'b1, 1'b1);
    load_step(cpvs_pkg::ST_RESET, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
  endtask

  // Option off: start goes to finish, release falls through to the untimed up check.
  task automatic test_pin_disabled();
    write_all(1'b0, 1'b1, 16'd0, 16'd0);
    load_step(cpvs_pkg::ST_START, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    load_step(cpvs_pkg::ST_RELEASE, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    load_step(cpvs_pkg::ST_CHECKUP, 1'b1);
    scan(1'b1, 1'b0, 1'b0);
  endtask

  // Hold-down mode, then the widest presets on both timers.
  task automatic test_hold_and_wide_presets();
    write_all(1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    load_step(cpvs_pkg::ST_START, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    settle_block();
    write_reg(cpvs_pkg::CFG_HOLD_NEXT, 16'd0);
    load_step(cpvs_pkg::ST_START, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    load_step(cpvs_pkg::ST_RELEASE, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
    scan(1'b0, 1'b0, 1'b0);
  endtask

  task automatic test_random_operation(input int n_items);
    int sent;
    int phase_len;
    int pick;
    sent = 0;
    while (sent < n_items) begin
      write_all($urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0, draw_ticks(),
                draw_ticks());
      no_gaps   = ($urandom_range(0, 2) == 0);
      phase_len = int'($urandom_range(60, 200));
      if (phase_len > n_items - sent) phase_len = n_items - sent;
      repeat (phase_len) begin
        pick = int'($urandom_range(0, 99));
        if ((m_step inside {cpvs_pkg::ST_IDLE, cpvs_pkg::ST_DONE, cpvs_pkg::ST_ALARM})
            && pick < 40)
          load_step(cpvs_pkg::ST_START, 1'($urandom_range(0, 1)));
        else if (pick < 5)
          load_step(cpvs_pkg::step_t'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        else if (pick < 8)
          send_beat(cpvs_pkg::op_t'($urandom_range(0, 1)),
                    cpvs_pkg::step_t'($urandom_range(0, 15)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        else
          scan($urandom_range(0, 4) == 0, $urandom_range(0, 3) == 0,
               $urandom_range(0, 9) == 0);
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  // Sink side: a random stall before each result beat.
  initial begin
    int gap;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    valve_result_t exp_r;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      if (pending_valve_results.size() == 0) begin
        $error("result beat with no expectation waiting");
        fail_count++;
      end else begin
        exp_r = pending_valve_results.pop_front();
        if (valve_down !== exp_r.valve_down) begin
          $error("valve_down: expected %0d, actual %0d", exp_r.valve_down, valve_down);
          fail_count++;
        end
        if (step_now !== exp_r.step_now) begin
          $error("step_now: expected %0d, actual %0d", exp_r.step_now, step_now);
          fail_count++;
        end
        if (delay_elapsed !== exp_r.delay_elapsed) begin
          $error("delay_elapsed: expected %0d, actual %0d", exp_r.delay_elapsed,
                 delay_elapsed);
          fail_count++;
        end
        if (alarm_elapsed !== exp_r.alarm_elapsed) begin
          $error("alarm_elapsed: expected %0d, actual %0d", exp_r.alarm_elapsed,
                 alarm_elapsed);
          fail_count++;
        end
        if (not_up_alarm !== exp_r.not_up_alarm) begin
          $error("not_up_alarm: expected %0d, actual %0d", exp_r.not_up_alarm,
                 not_up_alarm);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = cpvs_pkg::CFG_PIN_ENABLED;
    cfg_data       = '0;
    in_valid       = 1'b0;
    operation      = cpvs_pkg::OP_SCAN;
    new_step       = cpvs_pkg::ST_IDLE;
    up_limit       = 1'b0;
    blow_done      = 1'b0;
    clear_alarm    = 1'b0;
    no_gaps        = 1'b0;
    fail_count     = 0;
    stuck_cycles   = 0;
    r_pin_enabled  = 1'b0;
    r_hold_next    = 1'b0;
    r_down_delay   = '0;
    r_up_alarm     = '0;
    m_step         = cpvs_pkg::ST_IDLE;
    m_valve        = 1'b0;
    m_alarm        = 1'b0;
    m_delay_run    = 1'b0;
    m_delay_cnt    = '0;
    m_delay_preset = '0;
    m_limit_run    = 1'b0;
    m_limit_cnt    = '0;
    m_limit_preset = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;
    test_delayed_cycle();
    test_manual_steps();
    test_pin_disabled();
    test_hold_and_wide_presets();
    test_random_operation(1860);
    settle_block();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/cpvs_pkg.sv
hw/rtl/cooling_pin_valve_sequencer.sv
verif/tb_cooling_pin_valve_sequencer.sv
